FILE: sv/dq_pkg.sv
package dq_pkg;

  // Default sizes of the ring.
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed port field widths.
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd5;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd6;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: sv/dq_ram.sv
module dq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read-first: a write returns the word it replaces.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/double_ended_queue.sv
// Bounded double-ended queue kept in a single-port ring memory. One item is
// taken on every clock edge at which start is high; busy never rises, so a
// new item may follow in the very next cycle. For each item the memory is
// read and, if needed, written at the same slot, and the head pointer and
// count are updated. Its result appears in the next cycle, for exactly one
// cycle, with out_valid high; the registered read of the ring memory sets
// that delay. The receiver cannot stall the block and must take every
// result in the cycle it is shown.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [POS_W-1:0]    in_position,
  input  logic [IN_DW-1:0]    in_entry_data,
  output logic                out_valid,
  output logic [OUT_DW-1:0]   out_read_data,
  output logic [STATUS_W-1:0] out_status,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [OCC_W-1:0]      occ_r;
  logic                  data_sel_r, data_sel_nxt;

  logic                  acc;
  logic                  empty, full;
  logic [CMP_W-1:0]      pos_ext, cnt_ext, cnt_nxt_ext;
  logic                  pos_lt, pos_eq;
  logic [CNT_W-1:0]      offset;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sum_wrap;
  logic [PTR_W-1:0]      slot_off;
  logic [PTR_W-1:0]      head_inc, head_dec;

  logic                  ram_we;
  logic                  ram_we_sel;
  logic [PTR_W-1:0]      ram_addr;
  logic [63:0]           wr_wide, rd_wide;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // Every request is finished in the cycle it is taken.
  assign busy = 1'b0;
  assign acc  = start;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(CAPACITY));

  // Position checks against the current count.
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_lt  = (pos_ext < cnt_ext);
  assign pos_eq  = (pos_ext == cnt_ext);

  // Offset from the front for the slot that this request touches.
  always_comb begin
    case (in_req_type) inside
      REQ_PUSH_BACK:                offset = count_r;
      REQ_POP_BACK, REQ_PEEK_BACK:  offset = count_r - 1'b1;
      REQ_READ, REQ_WRITE:          offset = pos_ext[CNT_W-1:0];
      default:                      offset = '0;
    endcase
  end

  // Head plus offset, wrapped once around the ring.
  assign sum      = SUM_W'(head_r) + SUM_W'(offset);
  assign sum_wrap = (sum >= SUM_W'(CAPACITY)) ? sum - SUM_W'(CAPACITY) : sum;
  assign slot_off = sum_wrap[PTR_W-1:0];

  assign head_inc = (head_r == PTR_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_W'(CAPACITY - 1) : head_r - 1'b1;

  // Request decode: memory access, status and the next pointer and count.
  always_comb begin
    ram_we_sel   = 1'b0;
    ram_addr     = slot_off;
    status_nxt   = ST_OK;
    head_nxt     = head_r;
    count_nxt    = count_r;
    data_sel_nxt = 1'b0;
    unique case (in_req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we_sel = 1'b1;
          ram_addr   = head_dec;
          head_nxt   = head_dec;
          count_nxt  = count_r + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we_sel = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_addr     = head_r;
          data_sel_nxt = 1'b1;
          head_nxt     = head_inc;
          count_nxt    = count_r - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_sel_nxt = 1'b1;
          count_nxt    = count_r - 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_lt) begin
          data_sel_nxt = 1'b1;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      REQ_WRITE: begin
        if (pos_lt) begin
          // Replace in place; the read-first port returns the old word.
          ram_we_sel   = 1'b1;
          data_sel_nxt = 1'b1;
        end else if (pos_eq) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we_sel = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_addr     = head_r;
          data_sel_nxt = 1'b1;
        end
      end
      REQ_PEEK_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_sel_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_EMPTY;
      end
    endcase
  end

  assign ram_we    = acc & ram_we_sel;
  assign wr_wide   = 64'(in_entry_data);
  assign ram_wdata = wr_wide[DATA_WIDTH-1:0];

  dq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Ring pointer, count and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
      if (acc) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  assign cnt_nxt_ext = CMP_W'(count_nxt);

  // Result fields that travel alongside the memory read.
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r   <= status_nxt;
      occ_r      <= cnt_nxt_ext[OCC_W-1:0];
      data_sel_r <= data_sel_nxt;
    end
  end

  assign rd_wide       = 64'(ram_rdata);
  assign out_valid     = out_valid_r;
  assign out_read_data = data_sel_r ? rd_wide[OUT_DW-1:0] : '0;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  // Every accepted item gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("accepted item produced no result");

  // The count never goes past the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  // A full status is only reported when the ring was full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> ($past(count_r) == CNT_W'(CAPACITY)))
    else $error("full status on a ring that was not full");

  // Failed requests return zero data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_data == '0))
    else $error("failed request returned nonzero data");

endmodule

FILE: tb/tb.sv
module tb;
  import dq_pkg::*;

  localparam int RING_SLOTS = DEF_CAPACITY;
  localparam int HEAD_W     = $clog2(DEF_CAPACITY);

  // One result of the queue: the word returned, the status and the new occupancy.
  typedef struct packed {
    logic [OUT_DW-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } deq_result_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [REQ_W-1:0]    in_req_type   = REQ_PEEK_FRONT;
  logic [POS_W-1:0]    in_position   = '0;
  logic [IN_DW-1:0]    in_entry_data = '0;
  logic                busy;
  logic                out_valid;
  logic [OUT_DW-1:0]   out_read_data;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;

  // Shadow copy of the ring, its head and its fill level.
  logic [IN_DW-1:0]  model_ring [RING_SLOTS];
  logic [HEAD_W-1:0] model_head  = '0;
  logic [OCC_W-1:0]  model_count = '0;

  deq_result_t awaited_results [$];
  int          mismatch_count = 0;
  int          idle_pct       = 0;

  double_ended_queue dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_position   (in_position),
    .in_entry_data (in_entry_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Slot of the word at a given distance from the front; the head wraps by width.
  function automatic logic [HEAD_W-1:0] slot_at(input logic [OCC_W-1:0] offset);
    return model_head + offset[HEAD_W-1:0];
  endfunction

  // Applies one request to the shadow ring and returns the result it must produce.
  function automatic deq_result_t apply_request(input logic [REQ_W-1:0] req,
                                                input logic [POS_W-1:0] pos,
                                                input logic [IN_DW-1:0] word);
    deq_result_t r;
    logic        is_empty;
    logic        is_full;
    r.data    = '0;
    r.status  = ST_OK;
    is_empty  = (model_count == 0);
    is_full   = (model_count >= RING_SLOTS);
    case (req)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          model_head = model_head - 1'b1;
          model_ring[model_head] = word;
          model_count++;
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          model_ring[slot_at(model_count)] = word;
          model_count++;
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = model_ring[model_head];
          model_head = model_head + 1'b1;
          model_count--;
        end
      end
      REQ_POP_BACK: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = model_ring[slot_at(model_count - 1'b1)];
          model_count--;
        end
      end
      REQ_READ: begin
        if (pos < model_count) begin
          r.data = model_ring[slot_at(pos)];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      REQ_WRITE: begin
        if (pos < model_count) begin
          r.data = model_ring[slot_at(pos)];
          model_ring[slot_at(pos)] = word;
        end else if (pos == model_count) begin
          // Writing just past the back appends, subject to room.
          if (is_full) begin
            r.status = ST_FULL;
          end else begin
            model_ring[slot_at(model_count)] = word;
            model_count++;
          end
        end else begin
          r.status = ST_EMPTY;
        end
      end
      REQ_PEEK_FRONT: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = model_ring[model_head];
        end
      end
      default: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = model_ring[slot_at(model_count - 1'b1)];
        end
      end
    endcase
    r.occupancy = model_count;
    return r;
  endfunction

  // Random data word with the extremes weighted in.
  function automatic logic [IN_DW-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  // Sends one item, with random idle cycles in front of it, and records its result.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                           input logic [IN_DW-1:0] word);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_position   <= pos;
    in_entry_data <= word;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    awaited_results.push_back(apply_request(req, pos, word));
  endtask

  // Every result is compared with the oldest one still awaited.
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_read_data !== want.data) begin
          $error("out_read_data: expected %h, got %h", want.data, out_read_data);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("out_occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Each pop, peek, read and write request on an empty ring, including a write beyond the back.
  task automatic test_empty_ring();
    send_item(REQ_POP_FRONT, 5'd0, '1);
    send_item(REQ_POP_BACK, 5'd16, '0);
    send_item(REQ_PEEK_FRONT, 5'd0, '0);
    send_item(REQ_PEEK_BACK, 5'd0, '0);
    send_item(REQ_READ, 5'd0, '0);
    send_item(REQ_WRITE, 5'd1, 32'h1234_5678);
  endtask

  // Fill to capacity from both ends, then try to grow a full ring.
  task automatic test_fill_and_overflow();
    send_item(REQ_WRITE, 5'd0, '1);
    for (int i = 1; i < RING_SLOTS; i++) begin
      if (i % 2 == 1) begin
        send_item(REQ_PUSH_FRONT, 5'(i), (i == 1) ? '0 : pick_word());
      end else begin
        send_item(REQ_PUSH_BACK, 5'(i), $urandom);
      end
    end
    send_item(REQ_PUSH_BACK, 5'd0, 32'hDEAD_BEEF);
    send_item(REQ_WRITE, 5'd16, 32'hCAFE_F00D);
  endtask

  // Positions at the edge of the stored range, then shrink and append again.
  task automatic test_position_edges();
    send_item(REQ_READ, 5'd16, '0);
    send_item(REQ_WRITE, 5'd15, '0);
    send_item(REQ_PEEK_FRONT, 5'd0, '0);
    send_item(REQ_PEEK_BACK, 5'd0, '0);
    send_item(REQ_POP_FRONT, 5'd0, '0);
    send_item(REQ_POP_BACK, 5'd0, '0);
    send_item(REQ_WRITE, 5'd14, 32'h8000_0001);
  endtask

  // Random walk over the fill level; the push weight drifts so that the ring
  // goes from empty to full and back many times. A tenth of the items are noise.
  task automatic run_random_walk(input int n_items, input int idle, input bit bursty);
    int               push_weight;
    int               roll;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    push_weight = 50;
    idle_pct    = idle;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_weight = 15;
          1:       push_weight = 50;
          default: push_weight = 85;
        endcase
      end
      if (bursty && i % 30 == 0) begin
        idle_pct = (idle_pct == 0) ? 67 : 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        req = REQ_W'($urandom_range(0, 7));
        pos = POS_W'($urandom_range(0, 16));
      end else if ($urandom_range(0, 99) < push_weight) begin
        case ($urandom_range(0, 3))
          0:       req = REQ_PUSH_FRONT;
          1:       req = REQ_PUSH_BACK;
          2:       req = REQ_PUSH_FRONT;
          default: req = REQ_WRITE;
        endcase
        pos = (req == REQ_WRITE) ? model_count : POS_W'($urandom_range(0, 16));
      end else begin
        case ($urandom_range(0, 5))
          0:       req = REQ_POP_FRONT;
          1:       req = REQ_POP_BACK;
          2:       req = REQ_READ;
          3:       req = REQ_WRITE;
          4:       req = REQ_PEEK_FRONT;
          default: req = REQ_PEEK_BACK;
        endcase
        if (model_count != 0 && $urandom_range(0, 99) < 85) begin
          pos = POS_W'($urandom_range(0, model_count - 1));
        end else begin
          pos = POS_W'($urandom_range(0, 16));
        end
      end
      send_item(req, pos, pick_word());
    end
  endtask

  // Test sequence.
  initial begin
    int drain_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 0;
    test_empty_ring();
    test_fill_and_overflow();
    test_position_edges();
    run_random_walk(340, 0, 1'b0);
    run_random_walk(340, 67, 1'b0);
    run_random_walk(340, 17, 1'b0);
    run_random_walk(300, 0, 1'b1);
    start <= 1'b0;

    // Let the last results come out, then idle before the final check.
    drain_cycles = 0;
    while (awaited_results.size() != 0 && drain_cycles < 100) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/double_ended_queue.sv
tb/tb.sv
